### sv/diff_drive_wheel_odometry_macros.svh
// Assertion macros for the wheel odometry block.
`ifndef DIFF_DRIVE_WHEEL_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_WHEEL_ODOMETRY_MACROS_SVH
`ifndef SYNTHESIS
`define DDWO_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");
`define DDWO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");
`else
`define DDWO_ASSERT_IMPLY(label, ante, cons)
`define DDWO_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/ddwo_pkg.sv
// Types, constants and tables shared by the wheel odometry modules.
package ddwo_pkg;

    localparam logic [1:0] CMD_WHEEL = 2'd0;
    localparam logic [1:0] CMD_VEL   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic REG_SPEED_COEF = 1'b0;
    localparam logic REG_TURN_COEF  = 1'b1;

    localparam logic [23:0] SPEED_COEF_RESET = 24'd223127;
    localparam logic [23:0] TURN_COEF_RESET  = 24'd327680;

    localparam logic [7:0] DEST_BROADCAST = 8'hF0;
    localparam logic [7:0] DEST_NONE      = 8'h00;
    localparam logic [7:0] WHEEL_PORT     = 8'd7;

    localparam logic signed [27:0] PI_Q16     = 28'sd205887;
    localparam logic signed [27:0] TWO_PI_Q16 = 28'sd411775;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_WHEEL,
        KIND_VEL,
        KIND_TICK
    } in_kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WHEEL,
        OP_VELCMD,
        OP_TICK,
        OP_SUM,
        OP_MULR,
        OP_RATE,
        OP_MULT,
        OP_TSAT,
        OP_CINIT,
        OP_CITER,
        OP_MULV,
        OP_VEL,
        OP_DPOS,
        OP_POS,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MULR,
        ST_RATE,
        ST_MULT,
        ST_TSAT,
        ST_CINIT,
        ST_CITER,
        ST_MULV,
        ST_VEL,
        ST_DPOS,
        ST_POS,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        in_kind_t kind;
        logic     iter_last;
    } dp_status_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd843314857;
            5'd1:    val = 30'd497837830;
            5'd2:    val = 30'd263043837;
            5'd3:    val = 30'd133525159;
            5'd4:    val = 30'd67021688;
            5'd5:    val = 30'd33543516;
            5'd6:    val = 30'd16775851;
            5'd7:    val = 30'd8388438;
            5'd8:    val = 30'd4194283;
            5'd9:    val = 30'd2097149;
            5'd10:   val = 30'd1048576;
            5'd11:   val = 30'd524288;
            5'd12:   val = 30'd262144;
            5'd13:   val = 30'd131072;
            5'd14:   val = 30'd65536;
            5'd15:   val = 30'd32768;
            5'd16:   val = 30'd16384;
            5'd17:   val = 30'd8192;
            5'd18:   val = 30'd4096;
            5'd19:   val = 30'd2048;
            5'd20:   val = 30'd1024;
            5'd21:   val = 30'd512;
            5'd22:   val = 30'd256;
            5'd23:   val = 30'd128;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [42:0] v);
        logic signed [23:0] r;
        if (v > 43'sd8388607)
        begin
            r = 24'sd8388607;
        end
        else if (v < -43'sd8388608)
        begin
            r = -24'sd8388608;
        end
        else
        begin
            r = 24'(v);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -33'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

### sv/ddwo_ctrl.sv
// Sequencer for the wheel odometry block: steps the datapath and owns the handshakes.
module ddwo_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  ddwo_pkg::dp_status_t status,
    output ddwo_pkg::ctrl_cmd_t cmd
);

    ddwo_pkg::state_t state_reg;
    ddwo_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddwo_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.kind == ddwo_pkg::KIND_WHEEL)
                    begin
                        state_next = ddwo_pkg::ST_SUM;
                    end
                    else if (status.kind == ddwo_pkg::KIND_TICK)
                    begin
                        state_next = ddwo_pkg::ST_CINIT;
                    end
                end
            end
            ddwo_pkg::ST_SUM:   state_next = ddwo_pkg::ST_MULR;
            ddwo_pkg::ST_MULR:  state_next = ddwo_pkg::ST_RATE;
            ddwo_pkg::ST_RATE:  state_next = ddwo_pkg::ST_MULT;
            ddwo_pkg::ST_MULT:  state_next = ddwo_pkg::ST_TSAT;
            ddwo_pkg::ST_TSAT:  state_next = ddwo_pkg::ST_CINIT;
            ddwo_pkg::ST_CINIT: state_next = ddwo_pkg::ST_CITER;
            ddwo_pkg::ST_CITER:
            begin
                if (status.iter_last)
                begin
                    state_next = ddwo_pkg::ST_MULV;
                end
            end
            ddwo_pkg::ST_MULV:  state_next = ddwo_pkg::ST_VEL;
            ddwo_pkg::ST_VEL:   state_next = ddwo_pkg::ST_DPOS;
            ddwo_pkg::ST_DPOS:  state_next = ddwo_pkg::ST_POS;
            ddwo_pkg::ST_POS:   state_next = ddwo_pkg::ST_OUT;
            ddwo_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ddwo_pkg::ST_IDLE;
                end
            end
            default:            state_next = ddwo_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ddwo_pkg::ST_IDLE);
        cmd.op   = ddwo_pkg::OP_NONE;
        case (state_reg)
            ddwo_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (status.kind)
                        ddwo_pkg::KIND_WHEEL: cmd.op = ddwo_pkg::OP_WHEEL;
                        ddwo_pkg::KIND_VEL:   cmd.op = ddwo_pkg::OP_VELCMD;
                        ddwo_pkg::KIND_TICK:  cmd.op = ddwo_pkg::OP_TICK;
                        default:              cmd.op = ddwo_pkg::OP_NONE;
                    endcase
                end
            end
            ddwo_pkg::ST_SUM:   cmd.op = ddwo_pkg::OP_SUM;
            ddwo_pkg::ST_MULR:  cmd.op = ddwo_pkg::OP_MULR;
            ddwo_pkg::ST_RATE:  cmd.op = ddwo_pkg::OP_RATE;
            ddwo_pkg::ST_MULT:  cmd.op = ddwo_pkg::OP_MULT;
            ddwo_pkg::ST_TSAT:  cmd.op = ddwo_pkg::OP_TSAT;
            ddwo_pkg::ST_CINIT: cmd.op = ddwo_pkg::OP_CINIT;
            ddwo_pkg::ST_CITER: cmd.op = ddwo_pkg::OP_CITER;
            ddwo_pkg::ST_MULV:  cmd.op = ddwo_pkg::OP_MULV;
            ddwo_pkg::ST_VEL:   cmd.op = ddwo_pkg::OP_VEL;
            ddwo_pkg::ST_DPOS:  cmd.op = ddwo_pkg::OP_DPOS;
            ddwo_pkg::ST_POS:   cmd.op = ddwo_pkg::OP_POS;
            ddwo_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.op = ddwo_pkg::OP_OUT;
                end
            end
            default:            cmd.op = ddwo_pkg::OP_NONE;
        endcase
    end

    // Hold the result until the far side takes it.
    always_comb
    begin
        if (cmd.op == ddwo_pkg::OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddwo_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/ddwo_dp.sv
// Datapath of the wheel odometry block: rates, CORDIC sin/cos and pose update.
module ddwo_dp #(
    parameter int TRIG_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ddwo_pkg::ctrl_cmd_t cmd,
    output ddwo_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic [1:0]          command,
    input  logic [7:0]          source_address,
    input  logic [7:0]          dest_address,
    input  logic [7:0]          port_number,
    input  logic signed [15:0]  wheel_speed,
    input  logic [17:0]         elapsed_time,
    input  logic signed [23:0]  cmd_forward,
    input  logic signed [23:0]  cmd_lateral,
    input  logic signed [23:0]  cmd_turn,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [18:0]  heading,
    output logic signed [23:0]  rate_forward,
    output logic signed [23:0]  rate_lateral,
    output logic signed [23:0]  rate_turn
);

    localparam int ITER_W = $clog2(TRIG_STEPS);

    // Wheel slots by low source bits: right[1], right[0], left[1], left[0].
    logic signed [15:0] wheel_reg [4];
    logic [23:0]        speed_coef_reg;
    logic [23:0]        turn_coef_reg;
    logic signed [23:0] fwd_rate_reg;
    logic signed [23:0] lat_rate_reg;
    logic signed [23:0] turn_rate_reg;
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [18:0] heading_reg;

    logic [17:0]        dt_reg;
    logic signed [17:0] sum_all_reg;
    logic signed [17:0] diff_reg;
    logic signed [42:0] prod_fwd_reg;
    logic signed [42:0] prod_d_reg;
    logic signed [33:0] d_reg;
    logic signed [58:0] prod_t_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [34:0] z_reg;
    logic               flip_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic signed [57:0] p_fc_reg;
    logic signed [57:0] p_ls_reg;
    logic signed [57:0] p_fs_reg;
    logic signed [57:0] p_lc_reg;
    logic signed [28:0] vx_reg;
    logic signed [28:0] vy_reg;
    logic signed [42:0] ph_reg;
    logic signed [31:0] dx_reg;
    logic signed [31:0] dy_reg;
    logic signed [26:0] dth_reg;

    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [18:0] out_h_reg;
    logic signed [23:0] out_f_reg;
    logic signed [23:0] out_l_reg;
    logic signed [23:0] out_t_reg;

    logic signed [18:0] dt_s;
    logic signed [42:0] prod_fwd;
    logic signed [42:0] prod_d;
    logic signed [42:0] fwd_sh;
    logic signed [58:0] prod_t;
    logic signed [42:0] turn_sh;
    logic signed [34:0] z_init;
    logic signed [33:0] shx;
    logic signed [33:0] shy;
    logic signed [34:0] atan_s;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
    logic signed [57:0] p_fc;
    logic signed [57:0] p_ls;
    logic signed [57:0] p_fs;
    logic signed [57:0] p_lc;
    logic signed [58:0] vx_full;
    logic signed [58:0] vy_full;
    logic signed [42:0] ph;
    logic signed [47:0] pdx;
    logic signed [47:0] pdy;
    logic signed [31:0] pos_x_next;
    logic signed [31:0] pos_y_next;
    logic signed [27:0] th_sum;
    logic signed [27:0] th_wrap;
    logic signed [18:0] heading_next;

    always_comb
    begin
        status.iter_last = (iter_reg == ITER_W'(TRIG_STEPS - 1));
        case (command)
            ddwo_pkg::CMD_WHEEL:
            begin
                if ((source_address inside {[8'h08:8'h0B]})
                    && (dest_address inside {ddwo_pkg::DEST_BROADCAST, ddwo_pkg::DEST_NONE})
                    && (port_number == ddwo_pkg::WHEEL_PORT))
                begin
                    status.kind = ddwo_pkg::KIND_WHEEL;
                end
                else
                begin
                    status.kind = ddwo_pkg::KIND_DROP;
                end
            end
            ddwo_pkg::CMD_VEL:  status.kind = ddwo_pkg::KIND_VEL;
            ddwo_pkg::CMD_TICK: status.kind = ddwo_pkg::KIND_TICK;
            default:            status.kind = ddwo_pkg::KIND_DROP;
        endcase
    end

    assign dt_s     = $signed({1'b0, dt_reg});
    assign prod_fwd = sum_all_reg * $signed({1'b0, speed_coef_reg});
    assign prod_d   = diff_reg * $signed({1'b0, speed_coef_reg});
    assign fwd_sh   = prod_fwd_reg >>> 10;
    assign prod_t   = d_reg * $signed({1'b0, turn_coef_reg});
    assign turn_sh  = 43'(prod_t_reg >>> 16);

    assign z_init = $signed({{2{heading_reg[18]}}, heading_reg, 14'b0});
    assign shx    = x_reg >>> iter_reg;
    assign shy    = y_reg >>> iter_reg;
    assign atan_s = $signed({5'b0, ddwo_pkg::atan_q30(5'(iter_reg))});

    // Undo the fold by pi: negate both results.
    assign cos_v = flip_reg ? -x_reg : x_reg;
    assign sin_v = flip_reg ? -y_reg : y_reg;
    assign p_fc  = fwd_rate_reg * cos_v;
    assign p_ls  = lat_rate_reg * sin_v;
    assign p_fs  = fwd_rate_reg * sin_v;
    assign p_lc  = lat_rate_reg * cos_v;

    assign vx_full = 59'(p_fc_reg) - 59'(p_ls_reg);
    assign vy_full = 59'(p_fs_reg) + 59'(p_lc_reg);
    assign ph      = turn_rate_reg * dt_s;
    assign pdx     = vx_reg * dt_s;
    assign pdy     = vy_reg * dt_s;

    assign pos_x_next = ddwo_pkg::sat32(33'(pos_x_reg) + 33'(dx_reg));
    assign pos_y_next = ddwo_pkg::sat32(33'(pos_y_reg) + 33'(dy_reg));
    assign th_sum     = 28'(heading_reg) + 28'(dth_reg);

    // Wrap once by two pi, then clamp to plus or minus pi.
    always_comb
    begin
        th_wrap = th_sum;
        if (th_sum > ddwo_pkg::PI_Q16)
        begin
            th_wrap = th_sum - ddwo_pkg::TWO_PI_Q16;
        end
        else if (th_sum < -ddwo_pkg::PI_Q16)
        begin
            th_wrap = th_sum + ddwo_pkg::TWO_PI_Q16;
        end
        if (th_wrap > ddwo_pkg::PI_Q16)
        begin
            heading_next = 19'(ddwo_pkg::PI_Q16);
        end
        else if (th_wrap < -ddwo_pkg::PI_Q16)
        begin
            heading_next = 19'(-ddwo_pkg::PI_Q16);
        end
        else
        begin
            heading_next = 19'(th_wrap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                wheel_reg[i] <= '0;
            end
            speed_coef_reg <= ddwo_pkg::SPEED_COEF_RESET;
            turn_coef_reg  <= ddwo_pkg::TURN_COEF_RESET;
            fwd_rate_reg   <= '0;
            lat_rate_reg   <= '0;
            turn_rate_reg  <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ddwo_pkg::REG_SPEED_COEF)
                begin
                    speed_coef_reg <= cfg_data;
                end
                else
                begin
                    turn_coef_reg <= cfg_data;
                end
            end
            case (cmd.op)
                ddwo_pkg::OP_WHEEL:  wheel_reg[source_address[1:0]] <= wheel_speed;
                ddwo_pkg::OP_VELCMD:
                begin
                    fwd_rate_reg  <= cmd_forward;
                    lat_rate_reg  <= cmd_lateral;
                    turn_rate_reg <= cmd_turn;
                end
                ddwo_pkg::OP_RATE:   fwd_rate_reg <= ddwo_pkg::sat24(fwd_sh);
                ddwo_pkg::OP_TSAT:   turn_rate_reg <= ddwo_pkg::sat24(turn_sh);
                ddwo_pkg::OP_POS:
                begin
                    pos_x_reg   <= pos_x_next;
                    pos_y_reg   <= pos_y_next;
                    heading_reg <= heading_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ddwo_pkg::OP_WHEEL: dt_reg <= elapsed_time;
            ddwo_pkg::OP_TICK:  dt_reg <= elapsed_time;
            ddwo_pkg::OP_SUM:
            begin
                sum_all_reg <= 18'(wheel_reg[0]) + 18'(wheel_reg[1])
                             + 18'(wheel_reg[2]) + 18'(wheel_reg[3]);
                diff_reg    <= 18'(wheel_reg[0]) + 18'(wheel_reg[1])
                             - 18'(wheel_reg[2]) - 18'(wheel_reg[3]);
            end
            ddwo_pkg::OP_MULR:
            begin
                prod_fwd_reg <= prod_fwd;
                prod_d_reg   <= prod_d;
            end
            ddwo_pkg::OP_RATE:  d_reg <= 34'(prod_d_reg >>> 9);
            ddwo_pkg::OP_MULT:  prod_t_reg <= prod_t;
            ddwo_pkg::OP_CINIT:
            begin
                x_reg    <= ddwo_pkg::GAIN_Q30;
                y_reg    <= '0;
                iter_reg <= '0;
                if (z_init > ddwo_pkg::HALF_PI_Q30)
                begin
                    z_reg    <= z_init - ddwo_pkg::PI_Q30;
                    flip_reg <= 1'b1;
                end
                else if (z_init < -ddwo_pkg::HALF_PI_Q30)
                begin
                    z_reg    <= z_init + ddwo_pkg::PI_Q30;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= z_init;
                    flip_reg <= 1'b0;
                end
            end
            ddwo_pkg::OP_CITER:
            begin
                iter_reg <= iter_reg + ITER_W'(1);
                if (!z_reg[34])
                begin
                    x_reg <= x_reg - shy;
                    y_reg <= y_reg + shx;
                    z_reg <= z_reg - atan_s;
                end
                else
                begin
                    x_reg <= x_reg + shy;
                    y_reg <= y_reg - shx;
                    z_reg <= z_reg + atan_s;
                end
            end
            ddwo_pkg::OP_MULV:
            begin
                p_fc_reg <= p_fc;
                p_ls_reg <= p_ls;
                p_fs_reg <= p_fs;
                p_lc_reg <= p_lc;
            end
            ddwo_pkg::OP_VEL:
            begin
                vx_reg <= 29'(vx_full >>> 30);
                vy_reg <= 29'(vy_full >>> 30);
                ph_reg <= ph;
            end
            ddwo_pkg::OP_DPOS:
            begin
                dx_reg  <= 32'(pdx >>> 16);
                dy_reg  <= 32'(pdy >>> 16);
                dth_reg <= 27'(ph_reg >>> 16);
            end
            ddwo_pkg::OP_OUT:
            begin
                out_x_reg <= pos_x_reg;
                out_y_reg <= pos_y_reg;
                out_h_reg <= heading_reg;
                out_f_reg <= fwd_rate_reg;
                out_l_reg <= lat_rate_reg;
                out_t_reg <= turn_rate_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign pos_x        = out_x_reg;
    assign pos_y        = out_y_reg;
    assign heading      = out_h_reg;
    assign rate_forward = out_f_reg;
    assign rate_lateral = out_l_reg;
    assign rate_turn    = out_t_reg;

endmodule

### sv/diff_drive_wheel_odometry.sv
// Top level of the differential-drive wheel odometry block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  request  | in_valid / in_stall  | command, addresses, port, speed, time, rates
//  result   | out_valid / out_stall| pos_x, pos_y, heading, rate_*
//  config   | cfg_we               | cfg_index, cfg_data
//
// A wheel report runs the rate steps, then the CORDIC and pose steps; a tick runs only
// the CORDIC and pose steps. The CORDIC loop does one rotation step per cycle. A
// velocity command or a dropped request is taken straight from idle. Reset clears the
// wheel speeds, rates and pose and loads the coefficient defaults. One result may
// wait on out_stall while the next request runs; that next one holds in its last
// step, with in_stall high, until the waiting result leaves.
`include "diff_drive_wheel_odometry_macros.svh"

module diff_drive_wheel_odometry #(
    parameter int TRIG_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [7:0]         source_address,
    input  logic [7:0]         dest_address,
    input  logic [7:0]         port_number,
    input  logic signed [15:0] wheel_speed,
    input  logic [17:0]        elapsed_time,
    input  logic signed [23:0] cmd_forward,
    input  logic signed [23:0] cmd_lateral,
    input  logic signed [23:0] cmd_turn,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [18:0] heading,
    output logic signed [23:0] rate_forward,
    output logic signed [23:0] rate_lateral,
    output logic signed [23:0] rate_turn
);

    ddwo_pkg::ctrl_cmd_t  cmd;
    ddwo_pkg::dp_status_t status;

    ddwo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ddwo_dp #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .source_address (source_address),
        .dest_address   (dest_address),
        .port_number    (port_number),
        .wheel_speed    (wheel_speed),
        .elapsed_time   (elapsed_time),
        .cmd_forward    (cmd_forward),
        .cmd_lateral    (cmd_lateral),
        .cmd_turn       (cmd_turn),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .heading        (heading),
        .rate_forward   (rate_forward),
        .rate_lateral   (rate_lateral),
        .rate_turn      (rate_turn)
    );

    `DDWO_ASSERT_IMPLY(a_out_no_overwrite, cmd.op == ddwo_pkg::OP_OUT, !out_valid || !out_stall)
    `DDWO_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && status.kind == ddwo_pkg::KIND_TICK, in_stall)
    `DDWO_ASSERT_IMPLY(a_heading_range, out_valid, heading <= 19'sd205887 && heading >= -19'sd205887)

endmodule
